[rtl/rtcp_pkg.sv]
package rtcp_pkg;

	localparam int GRID_SIZE_DEF = 64;
	localparam int GROUP_W       = 16;
	localparam int COLOR_W       = 24;
	localparam int PIX_W         = 32;
	localparam int DIM_W         = 7;
	// group count per pixel: up to 128/16 = 8 over the whole grid range
	localparam int CNT_W         = 4;
	localparam int CFG_IDX_W     = 2;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

	typedef struct packed {
		logic [GROUP_W-1:0] mask;
		logic [GROUP_W-1:0] pattern;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		logic [CNT_W-1:0]   count;
		logic               img_end;
	} job_t;

endpackage

[rtl/rtcp_core.sv]
module rtcp_core import rtcp_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] cursor_width,
	input  logic [DIM_W-1:0] cursor_height,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] pixel,
	input  logic             out_free,
	output logic             job_load,
	output job_t             job
);

	localparam int CW = $clog2(GRID_SIZE);
	localparam int DW = CW + 1;
	localparam int LW = (DW > DIM_W) ? DW : DIM_W;
	localparam int NG = (GRID_SIZE + GROUP_W - 1) / GROUP_W;

	logic             v_s1;
	logic [PIX_W-1:0] pix_s1;

	logic [CW-1:0]      col_q;
	logic [CW-1:0]      row_q;
	logic [GROUP_W-1:0] mask_q;
	logic [GROUP_W-1:0] pat_q;
	logic [PIX_W-1:0]   bg_q;
	logic [PIX_W-1:0]   fg_q;

	logic [CW-1:0]      col;
	logic [CW-1:0]      grp_end_col;
	logic [3:0]         pad;
	logic [LW-1:0]      w_eff;
	logic [LW-1:0]      h_eff;
	logic [LW-1:0]      w_ext;
	logic [LW-1:0]      h_ext;
	logic               row_end;
	logic               img_end;
	logic               gend;
	logic               opaque;
	logic               mbit;
	logic               pbit;
	logic [PIX_W-1:0]   bg_new;
	logic [PIX_W-1:0]   fg_new;
	logic [GROUP_W-1:0] m_sh;
	logic [GROUP_W-1:0] p_sh;
	logic [CNT_W-1:0]   n;
	logic               adv;

	always_comb begin
		w_ext = LW'(cursor_width);
		h_ext = LW'(cursor_height);
		if (w_ext == '0)
			w_eff = LW'(1);
		else if (w_ext > LW'(GRID_SIZE))
			w_eff = LW'(GRID_SIZE);
		else
			w_eff = w_ext;
		if (h_ext == '0)
			h_eff = LW'(1);
		else if (h_ext > LW'(GRID_SIZE))
			h_eff = LW'(GRID_SIZE);
		else
			h_eff = h_ext;

		col = (col_q >= CW'(GRID_SIZE - 1)) ? CW'(GRID_SIZE - 1) : col_q;
		row_end = (LW'(col) + LW'(1)) >= w_eff;
		img_end = row_end && ((LW'(row_q) + LW'(1)) >= h_eff);

		opaque = |pix_s1[PIX_W-1:PIX_W-8];
		bg_new = bg_q;
		fg_new = fg_q;
		if (opaque) begin
			if (bg_q == '0)
				bg_new = pix_s1;
			else if (fg_q == '0 && pix_s1 != bg_q)
				fg_new = pix_s1;
		end
		mbit = opaque;
		pbit = opaque && (pix_s1 == fg_new);
		m_sh = {mask_q[GROUP_W-2:0], mbit};
		p_sh = {pat_q[GROUP_W-2:0], pbit};

		gend = (col[3:0] == 4'hf) || (col == CW'(GRID_SIZE - 1));
		// a closing pixel mid-group: shift up to the end of its group
		grp_end_col = ((col | CW'(15)) > CW'(GRID_SIZE - 1)) ? CW'(GRID_SIZE - 1)
			: (col | CW'(15));
		pad = gend ? 4'd0 : 4'(grp_end_col - col);

		if (row_end)
			n = CNT_W'(NG) - CNT_W'(col >> 4);
		else
			n = gend ? CNT_W'(1) : CNT_W'(0);

		adv      = v_s1 && (n == '0 || out_free);
		job_load = adv && (n != '0);
		in_ready = !v_s1 || adv;

		job.mask    = m_sh << pad;
		job.pattern = p_sh << pad;
		job.fg      = fg_new[COLOR_W-1:0];
		job.bg      = bg_new[COLOR_W-1:0];
		job.count   = n;
		job.img_end = img_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_valid || !in_ready;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			pix_s1 <= pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			mask_q <= '0;
			pat_q  <= '0;
			bg_q   <= '0;
			fg_q   <= '0;
		end else if (adv) begin
			if (img_end) begin
				col_q  <= '0;
				row_q  <= '0;
				mask_q <= '0;
				pat_q  <= '0;
				bg_q   <= '0;
				fg_q   <= '0;
			end else if (row_end) begin
				// next row's first group overwrites all sixteen bits
				col_q  <= '0;
				row_q  <= row_q + CW'(1);
				mask_q <= '0;
				pat_q  <= '0;
				bg_q   <= bg_new;
				fg_q   <= fg_new;
			end else begin
				col_q  <= col + CW'(1);
				mask_q <= m_sh;
				pat_q  <= p_sh;
				bg_q   <= bg_new;
				fg_q   <= fg_new;
			end
		end
	end

endmodule

[rtl/rtcp_out.sv]
module rtcp_out import rtcp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_load,
	input  job_t               job,
	output logic               out_free,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [GROUP_W-1:0] mask_word,
	output logic [GROUP_W-1:0] pattern_word,
	output logic [COLOR_W-1:0] fg_color,
	output logic [COLOR_W-1:0] bg_color,
	output logic               run_last,
	output logic               image_done
);

	logic [CNT_W-1:0]   cnt_q;
	logic               img_q;
	logic [GROUP_W-1:0] mask_q;
	logic [GROUP_W-1:0] pat_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;

	assign out_valid    = (cnt_q != '0);
	assign run_last     = (cnt_q == CNT_W'(1));
	assign image_done   = img_q && run_last;
	assign out_free     = !out_valid || (run_last && out_ready);
	assign mask_word    = mask_q;
	assign pattern_word = pat_q;
	assign fg_color     = fg_q;
	assign bg_color     = bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			img_q <= 1'b0;
		end else if (job_load) begin
			cnt_q <= job.count;
			img_q <= job.img_end;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// padding groups after the first are all transparent
	always_ff @(posedge clk) begin
		if (job_load) begin
			mask_q <= job.mask;
			pat_q  <= job.pattern;
			fg_q   <= job.fg;
			bg_q   <= job.bg;
		end else if (out_valid && out_ready) begin
			mask_q <= '0;
			pat_q  <= '0;
		end
	end

endmodule

[rtl/rgba_to_two_color_cursor_packer_top.sv]
// Path: a pixel transfer passes the input register, then the group register, before
//   its first group transfer; a busy group register can hold it in the input register.
// Throughput: one pixel per cycle; a pixel closing no group never waits. A row-closing
//   pixel emits up to GRID_SIZE/16 groups, one per cycle while out_ready is high, and a
//   later pixel that closes a group waits until the last group of that run is taken.
// Reset (arst_n low, asynchronous): counters, shift words and colours cleared,
//   both cursor dimensions back to 64, output empty.
module rgba_to_two_color_cursor_packer_top import rtcp_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	// pixel stream
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel,
	// group stream
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [GROUP_W-1:0]   mask_word,
	output logic [GROUP_W-1:0]   pattern_word,
	output logic [COLOR_W-1:0]   fg_color,
	output logic [COLOR_W-1:0]   bg_color,
	output logic                 run_last,
	output logic                 image_done
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             out_free;
	logic             job_load;
	job_t             job;

	// Registers take effect at once; writes are expected only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pixel stage: input register, colour capture, shift words and row/column
	// counters. A pixel that closes a group (or the row) hands one job to the
	// group register; a job holds the first group, the colours after this pixel
	// and how many groups its run holds. Pixels closing nothing pass without waiting.
	rtcp_core #(
		.GRID_SIZE(GRID_SIZE)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cursor_width (width_q),
		.cursor_height(height_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel        (pixel),
		.out_free     (out_free),
		.job_load     (job_load),
		.job          (job)
	);

	// Group register: plays a job out as consecutive transfers; the last
	// carries run_last, and image_done too when it closes the image.
	rtcp_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_load    (job_load),
		.job         (job),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mask_word   (mask_word),
		.pattern_word(pattern_word),
		.fg_color    (fg_color),
		.bg_color    (bg_color),
		.run_last    (run_last),
		.image_done  (image_done)
	);

endmodule

[rtl/rtcp_checker.sv]
module rtcp_checker import rtcp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [GROUP_W-1:0] mask_word,
	input logic [GROUP_W-1:0] pattern_word,
	input logic [COLOR_W-1:0] fg_color,
	input logic [COLOR_W-1:0] bg_color,
	input logic               run_last,
	input logic               image_done
);

	// stalled group holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mask_word)
			&& $stable(pattern_word) && $stable(run_last))
		else $error("group changed while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> run_last)
		else $error("image_done without run_last");

	// groups of one pixel leave back to back
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("gap inside a pixel's run of groups");

	a_run_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> $stable(fg_color) && $stable(bg_color))
		else $error("colours changed inside a pixel's run of groups");

endmodule

bind rgba_to_two_color_cursor_packer_top rtcp_checker u_rtcp_checker (.*);
